@@ hw/rtl/sdssf_pkg.sv @@
// ----------------------------------------------------------------------------
// sdssf_pkg
// Shared types, constants and the segment table for the signed decimal
// seven-segment formatter.
// ----------------------------------------------------------------------------
package sdssf_pkg;

  localparam int unsigned NumStages = 6;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned MagW      = 20;
  localparam int unsigned SegW      = 8;
  localparam int unsigned NumDigits = 6;
  localparam int unsigned WordW     = 3 * SegW;

  localparam logic [MagW-1:0] MaxMag   = 20'd999999;
  localparam logic [SegW-1:0] SegBlank = 8'h00;
  localparam logic [SegW-1:0] SegMinus = 8'h40;

  typedef logic [3:0] digit_t;
  typedef logic [SegW-1:0] seg_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } sdssf_ctrl_t;

  function automatic seg_t seg_encode(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/signed_decimal_seven_segment_format_core.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_format_core
// Throughput: one transaction per cycle through the six-stage pipeline, unless stall_i holds it.
// Stages: sign/saturate, split by 1000, split by 100 and 10, high digits, low digits, encode.
// Reset: asynchronous active-low reset empties the pipeline; no other state.
// ----------------------------------------------------------------------------
module signed_decimal_seven_segment_format_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [sdssf_pkg::ValueW-1:0] value_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [sdssf_pkg::WordW-1:0]   low_word_o,
  output logic [sdssf_pkg::WordW-1:0]   high_word_o,
  output logic                          overflow_o
);
  import sdssf_pkg::*;

  sdssf_ctrl_t ctrl;

  sdssf_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .out_stall_i (stall_i),
    .ctrl_o      (ctrl)
  );

  // x < 1000: quotient by 100 and by 10 through reciprocal multiplication
  function automatic digit_t div100(input logic [9:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd10486;
    return p[23:20];
  endfunction

  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd6554;
    return p[22:16];
  endfunction

  function automatic logic [9:0] times10(input logic [6:0] x);
    return (10'(x) << 3) + (10'(x) << 1);
  endfunction

  logic [NumStages-1:0] neg_q, ovf_q;

  // stage 0: sign and saturation
  logic [ValueW-1:0] abs_val;
  logic              sat;
  logic [MagW-1:0]   mag0_q;

  assign abs_val = value_i[ValueW-1] ? (ValueW'(0) - ValueW'(value_i)) : ValueW'(value_i);
  assign sat     = abs_val > ValueW'(MaxMag);

  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      neg_q[0] <= value_i[ValueW-1];
      ovf_q[0] <= sat;
      mag0_q   <= sat ? MaxMag : abs_val[MagW-1:0];
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctrl.en[k]) begin
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // stage 1: thousands quotient
  logic [40:0]     prod1000;
  logic [9:0]      hi1_q;
  logic [MagW-1:0] mag1_q;

  assign prod1000 = 41'(mag0_q) * 41'd1073742;

  always_ff @(posedge clk_i) begin
    if (ctrl.en[1]) begin
      hi1_q  <= prod1000[39:30];
      mag1_q <= mag0_q;
    end
  end

  // stage 2: low part, quotients of the high part
  logic [MagW-1:0] hi_x1000;
  logic [9:0]      lo2_q, hi2_q;
  digit_t          hh2_q;
  logic [6:0]      ht2_q;

  assign hi_x1000 = (MagW'(hi1_q) << 10) - (MagW'(hi1_q) << 4) - (MagW'(hi1_q) << 3);

  always_ff @(posedge clk_i) begin
    if (ctrl.en[2]) begin
      lo2_q <= 10'(mag1_q - hi_x1000);
      hi2_q <= hi1_q;
      hh2_q <= div100(hi1_q);
      ht2_q <= div10(hi1_q);
    end
  end

  // stage 3: high digits, quotients of the low part
  digit_t     d0_3_q, d1_3_q, d2_3_q, lh3_q;
  logic [6:0] lt3_q;
  logic [9:0] lo3_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.en[3]) begin
      d0_3_q <= hh2_q;
      d1_3_q <= 4'(7'(ht2_q - 7'(times10(7'(hh2_q)))));
      d2_3_q <= 4'(hi2_q - times10(ht2_q));
      lh3_q  <= div100(lo2_q);
      lt3_q  <= div10(lo2_q);
      lo3_q  <= lo2_q;
    end
  end

  // stage 4: low digits
  digit_t dig4_q [NumDigits];

  always_ff @(posedge clk_i) begin
    if (ctrl.en[4]) begin
      dig4_q[0] <= d0_3_q;
      dig4_q[1] <= d1_3_q;
      dig4_q[2] <= d2_3_q;
      dig4_q[3] <= lh3_q;
      dig4_q[4] <= 4'(7'(lt3_q - 7'(times10(7'(lh3_q)))));
      dig4_q[5] <= 4'(lo3_q - times10(lt3_q));
    end
  end

  // stage 5: blanking, sign placement and segment encode
  logic [NumDigits:0] blank;
  seg_t               seg [NumDigits];
  logic [WordW-1:0]   low_q, high_q;

  always_comb begin
    blank[0] = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      blank[i+1] = blank[i] && (dig4_q[i] == 4'd0) && (i < NumDigits - 1);
    end
    for (int i = 0; i < NumDigits; i++) begin
      if (blank[i+1]) begin
        seg[i] = (neg_q[4] && !blank[i+2 > NumDigits ? NumDigits : i+2]
                  && (i + 1 < NumDigits)) ? SegMinus : SegBlank;
      end else begin
        seg[i] = seg_encode(dig4_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[5]) begin
      low_q  <= {seg[5], seg[4], seg[3]};
      high_q <= {seg[2], seg[1], seg[0]};
    end
  end

  assign valid_o     = ctrl.vld[NumStages-1];
  assign low_word_o  = low_q;
  assign high_word_o = high_q;
  assign overflow_o  = ovf_q[NumStages-1];

endmodule

@@ hw/rtl/sdssf_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdssf_pipe_ctrl
// Valid tracking and per-stage advance enables for the formatter pipeline;
// bubbles are squeezed out so a stall at the output only holds full stages.
// ----------------------------------------------------------------------------
module sdssf_pipe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic                  out_stall_i,
  output sdssf_pkg::sdssf_ctrl_t ctrl_o
);
  import sdssf_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign stall_o    = !en[0];
  assign ctrl_o.en  = en;
  assign ctrl_o.vld = vld_q;

endmodule
